>>> design/assert_macros.svh
// Assertion macros shared by the level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("level meter assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("level meter assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/lvlm_pkg.sv
// Package with shared types and constants of the level meter.
`default_nettype none
package lvlm_pkg;

  localparam int unsigned FIELD_W = 24;

  typedef struct packed {
    logic                      vld;
    logic        [FIELD_W-1:0] peak;
    logic signed [FIELD_W-1:0] minimum;
    logic signed [FIELD_W-1:0] maximum;
    logic                      ovf;
  } win_end_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

>>> design/lvlm_front.sv
// Per-sample accumulation of peak, min, max, count and sum of squares.
`default_nettype none
module lvlm_front
  import lvlm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned MAX_WINDOW  = 65536,
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + CNT_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FIELD_W-1:0] in_sample,
  input  wire logic               in_last,
  input  wire logic               take,
  output win_end_t                hand,
  output logic      [SUM_W-1:0]   end_sum,
  output logic      [CNT_W-1:0]   end_cnt
);

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned SQ_W = 2 * SB;
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [SB-1:0] s;
  logic        [SB-1:0] mag;
  logic                 accept;
  logic                 counting;

  logic        [SB-1:0]    peak_r, peak_nxt;
  logic signed [SB-1:0]    min_r, min_nxt;
  logic signed [SB-1:0]    max_r, max_nxt;
  logic        [CNT_W-1:0] cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic        [SUM_W-1:0] sum_r;

  logic        [SQ_W-1:0]  sq_r;
  logic                    sq_vld_r;
  logic                    sq_last_r;

  logic                    end_vld_r;
  logic        [FIELD_W-1:0] end_peak_r;
  logic signed [FIELD_W-1:0] end_min_r;
  logic signed [FIELD_W-1:0] end_max_r;
  logic                    end_ovf_r;
  logic        [SUM_W-1:0] end_sum_r;
  logic        [CNT_W-1:0] end_cnt_r;

  assign s        = signed'(in_sample[SB-1:0]);
  assign mag      = s[SB-1] ? SB'(~in_sample[SB-1:0] + 1'b1) : in_sample[SB-1:0];
  assign in_ready = !end_vld_r;
  assign accept   = in_valid && in_ready;
  assign counting = (cnt_r < CNT_W'(MAX_WINDOW));

  always_comb begin
    peak_nxt = (mag > peak_r) ? mag : peak_r;
    min_nxt  = (s < min_r) ? s : min_r;
    max_nxt  = (s > max_r) ? s : max_r;
    cnt_nxt  = counting ? cnt_r + 1'b1 : cnt_r;
    ovf_nxt  = ovf_r | !counting;
  end

  // Window statistics; a marked sample moves them to the end registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= '0;
      min_r     <= SMAX;
      max_r     <= SMIN;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      end_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          end_peak_r <= FIELD_W'(peak_nxt);
          end_min_r  <= FIELD_W'(min_nxt);
          end_max_r  <= FIELD_W'(max_nxt);
          end_ovf_r  <= ovf_nxt;
          end_cnt_r  <= cnt_nxt;
          end_vld_r  <= 1'b1;
          peak_r     <= '0;
          min_r      <= SMAX;
          max_r      <= SMIN;
          cnt_r      <= '0;
          ovf_r      <= 1'b0;
        end else begin
          peak_r <= peak_nxt;
          min_r  <= min_nxt;
          max_r  <= max_nxt;
          cnt_r  <= cnt_nxt;
          ovf_r  <= ovf_nxt;
        end
      end else if (take) begin
        end_vld_r <= 1'b0;
      end
    end
  end

  // Square stage: drop squares of samples past the window limit
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= counting ? SQ_W'(mag) * SQ_W'(mag) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sq_last_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      sq_vld_r  <= accept;
      sq_last_r <= accept && in_last;
      if (sq_vld_r) begin
        if (sq_last_r) begin
          end_sum_r <= sum_r + SUM_W'(sq_r);
          sum_r     <= '0;
        end else begin
          sum_r <= sum_r + SUM_W'(sq_r);
        end
      end
    end
  end

  assign hand.vld     = end_vld_r && !sq_last_r;
  assign hand.peak    = end_peak_r;
  assign hand.minimum = end_min_r;
  assign hand.maximum = end_max_r;
  assign hand.ovf     = end_ovf_r;
  assign end_sum      = end_sum_r;
  assign end_cnt      = end_cnt_r;

endmodule
`default_nettype wire

>>> design/lvlm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lvlm_div
  import lvlm_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 65,
  parameter int unsigned DIVISOR_W  = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int unsigned CW = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  div_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    sh;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    sh      = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = sh - {1'b0, div_r};
    ge      = (sh >= {1'b0, div_r});
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= CW'(DIVIDEND_W - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> design/lvlm_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module lvlm_sqrt
  import lvlm_pkg::*;
#(
  parameter int unsigned ROOT_W = 24,
  localparam int unsigned RAD_W = 2 * ROOT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  localparam int unsigned CW = $clog2(ROOT_W);

  logic [RAD_W-1:0]  x_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W+1:0] sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  always_comb begin
    sh    = {rem_r[ROOT_W-1:0], x_r[RAD_W-1:RAD_W-2]};
    trial = {root_r, 2'b01};
    ge    = (sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CW'(ROOT_W - 1);
    end else if (busy_r) begin
      x_r    <= {x_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? sh - trial : sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

>>> design/window_peak_minmax_rms_meter.sv
// Top level of the windowed peak, min/max and RMS level meter.
// Samples (signed, low SAMPLE_BITS bits of in_sample) transfer in at one per
// cycle while in_ready is high; the sample with in_last high closes a window
// and yields one result transfer carrying peak magnitude, minimum, maximum,
// the RMS floor(sqrt(floor(sum_of_squares / count))) and an overflow flag.
// Windows longer than MAX_WINDOW keep the sum and count of their first
// MAX_WINDOW samples and report out_overflowed. The front part squares each
// sample in a one-stage multiplier and accumulates at full rate within a
// window. At the end of a window the totals go to a back part: a bit-serial
// divider over a 2*SAMPLE_BITS + clog2(MAX_WINDOW+1)-bit dividend (65 bits
// at the defaults), then a square root giving a SAMPLE_BITS-bit result, which
// the result register holds until out_ready. After every closing sample
// in_ready drops until the back part takes the window's totals: only while
// the last square settles into the sum when the back part is idle, otherwise
// until the previous result has been taken. The back part works on one
// window at a time, so a window that closes while it is busy stalls the
// input at its closing sample.
`default_nettype none
`include "assert_macros.svh"
module window_peak_minmax_rms_meter
  import lvlm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [FIELD_W-1:0] in_sample,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic             [FIELD_W-1:0] out_peak,
  output logic signed      [FIELD_W-1:0] out_minimum,
  output logic signed      [FIELD_W-1:0] out_maximum,
  output logic             [FIELD_W-1:0] out_rms_level,
  output logic                           out_overflowed
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + CNT_W;
  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;

  win_end_t             hand;
  logic     [SUM_W-1:0] end_sum;
  logic     [CNT_W-1:0] end_cnt;
  logic                 take;
  logic                 div_done;
  logic     [SUM_W-1:0] quotient;
  logic                 root_start;
  logic                 root_done;
  logic [SAMPLE_BITS-1:0] root;

  back_state_t state_r, state_nxt;

  // Result register: holds the finished window until the out side takes it
  logic        [FIELD_W-1:0] res_peak_r;
  logic signed [FIELD_W-1:0] res_min_r;
  logic signed [FIELD_W-1:0] res_max_r;
  logic                      res_ovf_r;
  logic        [FIELD_W-1:0] res_rms_r;

  lvlm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .take      (take),
    .hand      (hand),
    .end_sum   (end_sum),
    .end_cnt   (end_cnt)
  );

  // The count is never zero here: a window holds at least its closing sample and the count saturates at MAX_WINDOW
  lvlm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (take),
    .dividend (end_sum),
    .divisor  (end_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // The mean never exceeds the largest square, so its low RAD_W bits suffice
  lvlm_sqrt #(
    .ROOT_W (SAMPLE_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (quotient[RAD_W-1:0]),
    .done     (root_done),
    .root     (root)
  );

  // Back-part sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (hand.vld) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_ROOT;
      ST_ROOT: if (root_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Back-part sequencer: outputs
  always_comb begin
    take       = 1'b0;
    root_start = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: take       = hand.vld;
      ST_DIV:  root_start = div_done;
      ST_ROOT: ;
      ST_OUT:  out_valid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture window statistics on take, the root when it completes
  always_ff @(posedge clk) begin
    if (take) begin
      res_peak_r <= hand.peak;
      res_min_r  <= hand.minimum;
      res_max_r  <= hand.maximum;
      res_ovf_r  <= hand.ovf;
    end
    if (root_done) begin
      res_rms_r <= FIELD_W'(root);
    end
  end

  assign out_peak       = res_peak_r;
  assign out_minimum    = res_min_r;
  assign out_maximum    = res_max_r;
  assign out_rms_level  = res_rms_r;
  assign out_overflowed = res_ovf_r;

  // A closed window waiting for the back part blocks further samples
  `ASSERT_ALWAYS(a_hand_blocks_in, clk, rst_n, !hand.vld || !in_ready)
  // Divider and root finish only in the step that waits for them
  `ASSERT_ALWAYS(a_div_done_state, clk, rst_n, !div_done || (state_r == ST_DIV))
  `ASSERT_ALWAYS(a_root_done_state, clk, rst_n, !root_done || (state_r == ST_ROOT))
  // RMS never exceeds the peak, and min never exceeds max
  `ASSERT_ALWAYS(a_rms_le_peak, clk, rst_n, !out_valid || (out_rms_level <= out_peak))
  `ASSERT_ALWAYS(a_min_le_max, clk, rst_n, !out_valid || (out_minimum <= out_maximum))
  // The back part takes a window only from idle, then starts dividing
  `ASSERT_NEXT(a_take_to_div, clk, rst_n, take, state_r == ST_DIV)

endmodule
`default_nettype wire
